### hdl/ufq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ufq_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [WIDTH-1:0] elem_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        FN_ENQ = 1'b0,
        FN_DEQ = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic rd_en;
        ptr_t rd_addr;
        logic wr_en;
        ptr_t wr_addr;
    } mem_req_t;

    function automatic ptr_t next_slot(ptr_t p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    function automatic elem_t to_elem(logic [31:0] v);
        logic [63:0] ext;
        ext = {32'd0, v};
        return ext[WIDTH-1:0];
    endfunction

    function automatic logic [31:0] from_elem(elem_t e);
        logic [63:0] ext;
        ext = '0;
        ext[WIDTH-1:0] = e;
        return ext[31:0];
    endfunction

endpackage

`default_nettype wire

### hdl/ufq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module ufq_store (
    input  wire logic              aclk,
    input  wire ufq_pkg::mem_req_t req,
    input  wire ufq_pkg::elem_t    wr_data,
    output ufq_pkg::elem_t         rd_data
);

    ufq_pkg::elem_t mem [ufq_pkg::DEPTH];
    ufq_pkg::elem_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/unique_fifo_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// From accept to result valid, a rejected item or an enqueue into an empty queue passes
// idle and finish; a dequeue passes idle, deq and finish; a scanning enqueue idle, scan, finish.
// One item is handled at a time; the scan reads one stored entry per cycle through the
// single read port of the entry memory, then writes the new entry if no duplicate is found.
// A new item is taken while a result still waits on the output register.
// Reset clears pointers, count and handshake state; entry memory is not cleared.

module unique_fifo_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_out_value,
    output logic [4:0]       m_count,
    output logic             m_is_empty,
    output logic             m_is_full
);

    ufq_pkg::state_t  state_reg, state_next;
    ufq_pkg::ptr_t    wr_ptr_reg, wr_ptr_next;
    ufq_pkg::ptr_t    rd_ptr_reg, rd_ptr_next;
    ufq_pkg::ptr_t    scan_ptr_reg, scan_ptr_next;
    ufq_pkg::cnt_t    held_reg, held_next;
    ufq_pkg::cnt_t    iss_cnt_reg, iss_cnt_next;
    ufq_pkg::cnt_t    cmp_cnt_reg, cmp_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    ufq_pkg::elem_t   elem_reg, elem_next;
    ufq_pkg::status_t res_status_reg, res_status_next;
    logic [31:0]      res_value_reg, res_value_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [31:0]      m_out_value_reg, m_out_value_next;
    logic [4:0]       m_count_reg, m_count_next;
    logic             m_is_empty_reg, m_is_empty_next;
    logic             m_is_full_reg, m_is_full_next;

    ufq_pkg::mem_req_t mem_req;
    ufq_pkg::elem_t    rd_data;
    ufq_pkg::elem_t    wr_data;
    ufq_pkg::cnt_t     cmp_cnt_inc;
    logic              is_full_now;
    logic              is_empty_now;

    ufq_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign is_full_now  = (held_reg == ufq_pkg::CNT_W'(ufq_pkg::DEPTH));
    assign is_empty_now = (held_reg == '0);
    assign cmp_cnt_inc  = cmp_cnt_reg + ufq_pkg::CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ufq_pkg::S_IDLE;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            held_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            held_reg    <= held_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg    <= scan_ptr_next;
        iss_cnt_reg     <= iss_cnt_next;
        cmp_cnt_reg     <= cmp_cnt_next;
        elem_reg        <= elem_next;
        res_status_reg  <= res_status_next;
        res_value_reg   <= res_value_next;
        m_status_reg    <= m_status_next;
        m_out_value_reg <= m_out_value_next;
        m_count_reg     <= m_count_next;
        m_is_empty_reg  <= m_is_empty_next;
        m_is_full_reg   <= m_is_full_next;
    end

    always_comb begin
        state_next       = state_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        scan_ptr_next    = scan_ptr_reg;
        held_next        = held_reg;
        iss_cnt_next     = iss_cnt_reg;
        cmp_cnt_next     = cmp_cnt_reg;
        rd_vld_next      = 1'b0;
        elem_next        = elem_reg;
        res_status_next  = res_status_reg;
        res_value_next   = res_value_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_out_value_next = m_out_value_reg;
        m_count_next     = m_count_reg;
        m_is_empty_next  = m_is_empty_reg;
        m_is_full_next   = m_is_full_reg;
        mem_req          = '0;
        wr_data          = elem_reg;
        s_ready          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ufq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    elem_next      = ufq_pkg::to_elem(s_value);
                    res_value_next = '0;
                    if (s_func == ufq_pkg::FN_ENQ) begin
                        if (is_full_now) begin
                            res_status_next = ufq_pkg::ST_FULL;
                            state_next      = ufq_pkg::S_FINISH;
                        end else if (is_empty_now) begin
                            // nothing to compare against: store right away
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = wr_ptr_reg;
                            wr_data         = ufq_pkg::to_elem(s_value);
                            wr_ptr_next     = ufq_pkg::next_slot(wr_ptr_reg);
                            held_next       = held_reg + ufq_pkg::CNT_W'(1);
                            res_status_next = ufq_pkg::ST_DONE;
                            state_next      = ufq_pkg::S_FINISH;
                        end else begin
                            scan_ptr_next = rd_ptr_reg;
                            iss_cnt_next  = '0;
                            cmp_cnt_next  = '0;
                            state_next    = ufq_pkg::S_SCAN;
                        end
                    end else begin
                        if (is_empty_now) begin
                            res_status_next = ufq_pkg::ST_EMPTY;
                            state_next      = ufq_pkg::S_FINISH;
                        end else begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = rd_ptr_reg;
                            state_next      = ufq_pkg::S_DEQ;
                        end
                    end
                end
            end

            ufq_pkg::S_SCAN: begin
                // issue one read per cycle, compare the previous one
                if (iss_cnt_reg != held_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_ptr_reg;
                    scan_ptr_next   = ufq_pkg::next_slot(scan_ptr_reg);
                    iss_cnt_next    = iss_cnt_reg + ufq_pkg::CNT_W'(1);
                    rd_vld_next     = 1'b1;
                end
                if (rd_vld_reg) begin
                    if (rd_data == elem_reg) begin
                        res_status_next = ufq_pkg::ST_DUP;
                        rd_vld_next     = 1'b0;
                        state_next      = ufq_pkg::S_FINISH;
                    end else begin
                        cmp_cnt_next = cmp_cnt_inc;
                        if (cmp_cnt_inc == held_reg) begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = wr_ptr_reg;
                            wr_ptr_next     = ufq_pkg::next_slot(wr_ptr_reg);
                            held_next       = held_reg + ufq_pkg::CNT_W'(1);
                            res_status_next = ufq_pkg::ST_DONE;
                            rd_vld_next     = 1'b0;
                            state_next      = ufq_pkg::S_FINISH;
                        end
                    end
                end
            end

            ufq_pkg::S_DEQ: begin
                res_value_next  = ufq_pkg::from_elem(rd_data);
                res_status_next = ufq_pkg::ST_DONE;
                rd_ptr_next     = ufq_pkg::next_slot(rd_ptr_reg);
                held_next       = held_reg - ufq_pkg::CNT_W'(1);
                state_next      = ufq_pkg::S_FINISH;
            end

            ufq_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_out_value_next = res_value_reg;
                    m_count_next     = held_reg;
                    m_is_empty_next  = is_empty_now;
                    m_is_full_next   = is_full_now;
                    state_next       = ufq_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ufq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_value = m_out_value_reg;
    assign m_count     = m_count_reg;
    assign m_is_empty  = m_is_empty_reg;
    assign m_is_full   = m_is_full_reg;

endmodule

`default_nettype wire

### tb/unique_fifo_queue_tb.sv
`timescale 1ns / 1ps

module unique_fifo_queue_tb;

    typedef struct packed {
        ufq_pkg::status_t status;
        logic [31:0]      out_value;
        logic [4:0]       count;
        logic             is_empty;
        logic             is_full;
    } fifo_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [31:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_out_value;
    logic [4:0]  m_count;
    logic        m_is_empty;
    logic        m_is_full;

    unique_fifo_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_value (m_out_value),
        .m_count     (m_count),
        .m_is_empty  (m_is_empty),
        .m_is_full   (m_is_full)
    );

    // shadow copy of the queue contents
    ufq_pkg::elem_t slot_copy [ufq_pkg::DEPTH];
    ufq_pkg::ptr_t  wr_copy;
    ufq_pkg::ptr_t  rd_copy;
    ufq_pkg::cnt_t  held_copy;

    fifo_result_t pending_results [$];
    int  mismatches;
    int  results_seen;
    int  status_seen [4];
    int  items_sent;
    int  send_gap;
    bit  quiet;
    bit  rst_done;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic ufq_pkg::ptr_t bump(ufq_pkg::ptr_t p);
        return (p == ufq_pkg::ptr_t'(ufq_pkg::DEPTH - 1)) ? ufq_pkg::ptr_t'(0)
                                                          : ufq_pkg::ptr_t'(p + 1'b1);
    endfunction

    // Computes the result of one operation and advances the shadow queue.
    function automatic fifo_result_t fifo_apply_op(ufq_pkg::func_t f, logic [31:0] v);
        fifo_result_t   r;
        ufq_pkg::elem_t e;
        ufq_pkg::ptr_t  p;
        logic           hit;
        int             k;
        r = '0;
        r.status = ufq_pkg::ST_DONE;
        e = ufq_pkg::elem_t'(v);
        hit = 1'b0;
        if (f == ufq_pkg::FN_ENQ) begin
            if (held_copy == ufq_pkg::cnt_t'(ufq_pkg::DEPTH)) begin
                r.status = ufq_pkg::ST_FULL;
            end else begin
                p = rd_copy;
                for (k = 0; k < ufq_pkg::DEPTH; k++) begin
                    if (k < int'(held_copy) && slot_copy[p] == e) begin
                        hit = 1'b1;
                    end
                    p = bump(p);
                end
                if (hit) begin
                    r.status = ufq_pkg::ST_DUP;
                end else begin
                    slot_copy[wr_copy] = e;
                    wr_copy = bump(wr_copy);
                    held_copy = held_copy + 1'b1;
                end
            end
        end else begin
            if (held_copy == 0) begin
                r.status = ufq_pkg::ST_EMPTY;
            end else begin
                r.out_value = 32'(slot_copy[rd_copy]);
                rd_copy = bump(rd_copy);
                held_copy = held_copy - 1'b1;
            end
        end
        r.count    = 5'(held_copy);
        r.is_empty = (held_copy == 0);
        r.is_full  = (held_copy == ufq_pkg::cnt_t'(ufq_pkg::DEPTH));
        return r;
    endfunction

    task automatic send_item(ufq_pkg::func_t f, logic [31:0] v);
        repeat (send_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_func  <= f;
        s_value <= v;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(fifo_apply_op(f, v));
        items_sent++;
        send_gap = draw_gap();
        // keep valid up when the next item follows back to back
        if (send_gap != 0) begin
            s_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        if (send_gap == 0) begin
            s_valid <= 1'b0;
            send_gap = 1;
        end
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_empty_dequeue();
        send_item(ufq_pkg::FN_DEQ, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_fill_with_duplicates();
        int k;
        send_item(ufq_pkg::FN_ENQ, 32'h0000_0000);
        send_item(ufq_pkg::FN_ENQ, 32'hFFFF_FFFF);
        send_item(ufq_pkg::FN_ENQ, 32'hAAAA_AAAA);
        send_item(ufq_pkg::FN_ENQ, 32'h5555_5555);
        send_item(ufq_pkg::FN_ENQ, 32'h0000_0000);
        send_item(ufq_pkg::FN_ENQ, 32'hFFFF_FFFF);
        send_item(ufq_pkg::FN_ENQ, 32'h8000_0000);
        send_item(ufq_pkg::FN_ENQ, 32'h0000_0001);
        for (k = 0; k < ufq_pkg::DEPTH - 6; k++) begin
            send_item(ufq_pkg::FN_ENQ, 32'h1000_0000 + k);
        end
        drain_results();
    endtask

    task automatic test_full_rejects();
        send_item(ufq_pkg::FN_ENQ, 32'h1234_5678);
        // full and duplicate at once: full wins
        send_item(ufq_pkg::FN_ENQ, 32'hAAAA_AAAA);
        drain_results();
    endtask

    task automatic test_dequeue_order();
        repeat (3) send_item(ufq_pkg::FN_DEQ, $urandom);
        drain_results();
    endtask

    task automatic test_random_mix();
        logic [31:0] pool [8];
        int          phase;
        int          j;
        int          enq_pct;
        for (phase = 0; phase < 13; phase++) begin
            case ($urandom_range(0, 2))
                0: begin
                    enq_pct = 80;
                end
                1: begin
                    enq_pct = 25;
                end
                default: begin
                    enq_pct = 55;
                end
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (j = 0; j < 8; j++) begin
                pool[j] = $urandom;
            end
            if (phase % 2 == 0) begin
                pool[0] = 32'h0000_0000;
                pool[1] = 32'hFFFF_FFFF;
            end
            for (j = 0; j < 50; j++) begin
                if ($urandom_range(0, 99) < enq_pct) begin
                    // half the enqueues reuse a small pool so duplicates come often
                    if ($urandom_range(0, 1) == 1) begin
                        send_item(ufq_pkg::FN_ENQ, pool[$urandom_range(0, 7)]);
                    end else begin
                        send_item(ufq_pkg::FN_ENQ, $urandom);
                    end
                end else begin
                    send_item(ufq_pkg::FN_DEQ, $urandom);
                end
            end
            if (phase % 4 == 3) begin
                drain_results();
            end
        end
        quiet = 1'b0;
        drain_results();
    endtask

    initial begin : result_check
        int           stall;
        fifo_result_t want;
        logic         bad;
        m_ready <= 1'b0;
        wait (rst_done);
        @(posedge aclk);
        stall = draw_gap();
        forever begin
            repeat (stall) @(posedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            results_seen++;
            status_seen[m_status]++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: status=%0d value=%h count=%0d",
                             m_status, m_out_value, m_count);
                end
            end else begin
                want = pending_results.pop_front();
                bad = (m_status !== want.status) || (m_out_value !== want.out_value)
                    || (m_count !== want.count) || (m_is_empty !== want.is_empty)
                    || (m_is_full !== want.is_full);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: status=%0d value=%h count=%0d empty=%b full=%b",
                                 want.status, want.out_value, want.count,
                                 want.is_empty, want.is_full);
                        $display("         got: status=%0d value=%h count=%0d empty=%b full=%b",
                                 m_status, m_out_value, m_count, m_is_empty, m_is_full);
                    end
                end
            end
            stall = draw_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_func  <= ufq_pkg::FN_ENQ;
        s_value <= '0;
        wr_copy   = '0;
        rd_copy   = '0;
        held_copy = '0;
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        send_gap     = 1;
        quiet        = 1'b0;
        rst_done     = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        rst_done = 1'b1;
        @(posedge aclk);

        test_empty_dequeue();
        test_fill_with_duplicates();
        test_full_rejects();
        test_dequeue_order();
        test_random_mix();

        drain_results();
        repeat (40) @(posedge aclk);

        $display("sent %0d items, checked %0d results", items_sent, results_seen);
        $display("statuses: done %0d, duplicate %0d, full %0d, empty %0d",
                 status_seen[ufq_pkg::ST_DONE], status_seen[ufq_pkg::ST_DUP],
                 status_seen[ufq_pkg::ST_FULL], status_seen[ufq_pkg::ST_EMPTY]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
